// ===== sv/rc4cs_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4cs_pkg
// Shared types, codes and helpers for the RC4 cipher with checksum.
// ----------------------------------------------------------------------------
package rc4cs_pkg;

   localparam int BYTE_W     = 8;
   localparam int SBOX_DEPTH = 1 << BYTE_W;
   localparam int KIND_W     = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION = 1'b0;

   // item operation codes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // direction codes
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] kind;
      logic              checksum_ok;
      logic              end_of_run;
   } result_type;

   // one's-complement add with end-around carry
   function automatic logic [BYTE_W-1:0] ones_add(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, t[BYTE_W]};
   endfunction

endpackage

// ===== sv/rc4_cipher_with_checksum.sv =====
// ----------------------------------------------------------------------------
// rc4_cipher_with_checksum
// RC4 stream cipher with an 8-bit one's-complement message checksum.
// ----------------------------------------------------------------------------
// Input items arrive on req_* (valid/stall). A key item (op 0) is stored in
// the key memory while it has room; the key item marked last then runs the
// key schedule: an identity fill of the sbox memory, then per schedule step
// the reads of s[x] and s[y] and the swap writes on its single write port.
// A data item (op 1) runs the dependent sbox reads of s[i], s[j] and
// s[s[i]+s[j]], with the swap writes in between, before its result.
// The last encrypt item is followed by a checksum item; the last decrypt item
// gives its verify status instead of a data result.
// Results leave on rsp_* through one output register; the engine can accept
// a new item while a result waits there, and holds in place while
// rsp_stall is high and the register is full.
// After reset the sbox is filled with the identity with req_stall high.
// The direction register (address 0) is written through the APB port; the
// user must do so only while no item is in flight (not enforced here).
// ----------------------------------------------------------------------------
module rc4_cipher_with_checksum #(
   parameter int KEY_MAX_BYTES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic [1:0]                        rsp_kind,
   output logic                              rsp_checksum_ok,
   output logic                              rsp_end_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rc4cs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rc4cs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rc4cs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   logic                  direction;
   logic                  res_valid;
   logic                  res_ready;
   rc4cs_pkg::result_type res;
   logic                  rsp_valid_ff, rsp_valid_in;
   rc4cs_pkg::result_type rsp_ff, rsp_in;

   rc4cs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .direction (direction)
   );

   rc4cs_engine #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .direction     (direction),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .res_valid     (res_valid),
      .res           (res),
      .res_ready     (res_ready)
   );

   // output register frees up in the cycle its item is taken
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_ready ? res_valid : rsp_valid_ff;
   assign rsp_in       = (res_ready && res_valid) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_checksum_ok = rsp_ff.checksum_ok;
   assign rsp_end_of_run  = rsp_ff.end_of_run;

endmodule

// ===== sv/rc4cs_ram.sv =====
// ----------------------------------------------------------------------------
// rc4cs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rc4cs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/rc4cs_csr.sv =====
// ----------------------------------------------------------------------------
// rc4cs_csr
// Register port: holds the direction register, always ready.
// ----------------------------------------------------------------------------
module rc4cs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rc4cs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rc4cs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rc4cs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready,
   output logic                                 direction
);

   logic [rc4cs_pkg::CSR_IDX_W-1:0] reg_idx;
   logic                            wr_hit;
   logic                            direction_ff;
   logic                            direction_in;

   assign reg_idx = paddr[rc4cs_pkg::CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_hit  = psel && penable && pwrite && pready
                    && (reg_idx == rc4cs_pkg::REG_DIRECTION);

   assign direction_in = wr_hit ? pwdata[0] : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= rc4cs_pkg::DIR_ENCRYPT;
      end else begin
         direction_ff <= direction_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == rc4cs_pkg::REG_DIRECTION) begin
         prdata = {{(rc4cs_pkg::CSR_DATA_W-1){1'b0}}, direction_ff};
      end
   end

   assign direction = direction_ff;

endmodule

// ===== sv/rc4cs_engine.sv =====
// ----------------------------------------------------------------------------
// rc4cs_engine
// Sequencer around the sbox and key memories: key load, key schedule,
// keystream generation and checksum accumulation.
// ----------------------------------------------------------------------------
module rc4cs_engine #(
   parameter int KEY_MAX_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   direction,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last,
   output logic                   res_valid,
   output rc4cs_pkg::result_type  res,
   input  logic                   res_ready
);

   localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int KCNT_W = $clog2(KEY_MAX_BYTES + 1);
   localparam int BW     = rc4cs_pkg::BYTE_W;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_KS_RD,
      S_KS_Y,
      S_KS_WX,
      S_KS_WY,
      S_PR_J,
      S_PR_T,
      S_PR_WJ,
      S_OUT,
      S_CHK,
      S_STAT
   } state_type;

   state_type state_ff, state_in;

   logic [BW-1:0]     x_ff, x_in;
   logic [BW-1:0]     y_ff, y_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [KCNT_W-1:0] len_ff, len_in;
   logic [KCNT_W-1:0] kcnt_ff, kcnt_in;
   logic              sched_ff, sched_in;
   logic [BW-1:0]     i_ff, i_in;
   logic [BW-1:0]     j_ff, j_in;
   logic [BW-1:0]     si_ff, si_in;
   logic [BW-1:0]     sj_ff, sj_in;
   logic [BW-1:0]     t_ff, t_in;
   logic [BW-1:0]     ks_ff, ks_in;
   logic [BW-1:0]     byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [BW-1:0]     sum_ff, sum_in;

   // memory ports
   logic              s_wr_en;
   logic [BW-1:0]     s_wr_addr;
   logic [BW-1:0]     s_wr_data;
   logic [BW-1:0]     s_rd_addr;
   logic [BW-1:0]     s_rd_data;
   logic              k_wr_en;
   logic [BW-1:0]     k_rd_data;

   logic              encrypt;
   logic              key_room;
   logic [KCNT_W-1:0] kcnt_next;
   logic [BW-1:0]     ks_fwd;
   logic [BW-1:0]     ks_sel;
   logic [BW-1:0]     plain;
   logic [BW-1:0]     sum_opnd;
   logic [BW-1:0]     stat_sum;
   logic [BW-1:0]     j_new;
   logic [BW-1:0]     y_new;
   logic [BW-1:0]     t_new;
   logic              kidx_wrap;
   rc4cs_pkg::result_type data_res;

   rc4cs_ram #(
      .WIDTH (BW),
      .DEPTH (rc4cs_pkg::SBOX_DEPTH)
   ) u_sbox (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   rc4cs_ram #(
      .WIDTH (BW),
      .DEPTH (KEY_MAX_BYTES)
   ) u_key (
      .clock   (clock),
      .wr_en   (k_wr_en),
      .wr_addr (kcnt_ff[KIDX_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (kidx_ff),
      .rd_data (k_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign encrypt   = (direction == rc4cs_pkg::DIR_ENCRYPT);
   assign key_room  = (kcnt_ff < KCNT_W'(KEY_MAX_BYTES));
   assign kcnt_next = key_room ? (kcnt_ff + KCNT_W'(1)) : kcnt_ff;

   // s[i] was written in the previous cycle, s[j] is written this cycle
   assign ks_fwd = (t_ff == i_ff) ? sj_ff :
                   (t_ff == j_ff) ? si_ff : s_rd_data;
   assign ks_sel   = (state_ff == S_PR_WJ) ? ks_fwd : ks_ff;
   assign plain    = byte_ff ^ ks_sel;
   assign sum_opnd = encrypt ? plain : byte_ff;
   assign stat_sum = rc4cs_pkg::ones_add(sum_ff, byte_ff);
   assign j_new    = j_ff + s_rd_data;
   assign y_new    = y_ff + s_rd_data + k_rd_data;
   assign t_new    = si_ff + s_rd_data;
   assign kidx_wrap = ((KCNT_W'(kidx_ff) + KCNT_W'(1)) == len_ff);

   always_comb begin
      data_res.out_byte    = plain;
      data_res.kind        = rc4cs_pkg::KIND_DATA;
      data_res.checksum_ok = 1'b0;
      data_res.end_of_run  = !(encrypt && last_ff);
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      kidx_in   = kidx_ff;
      len_in    = len_ff;
      kcnt_in   = kcnt_ff;
      sched_in  = sched_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      si_in     = si_ff;
      sj_in     = sj_ff;
      t_in      = t_ff;
      ks_in     = ks_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      s_wr_en   = 1'b0;
      s_wr_addr = x_ff;
      s_wr_data = x_ff;
      s_rd_addr = x_ff;
      k_wr_en   = 1'b0;
      res_valid = 1'b0;
      res       = data_res;

      case (state_ff)
         S_INIT: begin
            // identity fill, one entry a cycle
            s_wr_en = 1'b1;
            x_in    = x_ff + 1'b1;
            if (x_ff == rc4cs_pkg::BYTE_ONES) begin
               state_in = sched_ff ? S_KS_RD : S_IDLE;
            end
         end
         S_IDLE: begin
            s_rd_addr = i_ff + 1'b1;
            if (req_valid) begin
               if (req_op == rc4cs_pkg::OP_KEY) begin
                  k_wr_en = key_room;
                  kcnt_in = kcnt_next;
                  if (req_last) begin
                     kcnt_in  = '0;
                     len_in   = kcnt_next;
                     kidx_in  = '0;
                     y_in     = '0;
                     sched_in = 1'b1;
                     state_in = S_INIT;
                  end
               end else begin
                  byte_in = req_data_byte;
                  last_in = req_last;
                  if (!encrypt && req_last) begin
                     state_in = S_STAT;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_PR_J;
                  end
               end
            end
         end
         S_KS_RD: begin
            s_rd_addr = x_ff;
            state_in  = S_KS_Y;
         end
         S_KS_Y: begin
            si_in     = s_rd_data;
            y_in      = y_new;
            s_rd_addr = y_new;
            state_in  = S_KS_WX;
         end
         S_KS_WX: begin
            s_wr_en   = 1'b1;
            s_wr_addr = x_ff;
            s_wr_data = s_rd_data;
            state_in  = S_KS_WY;
         end
         S_KS_WY: begin
            s_wr_en   = 1'b1;
            s_wr_addr = y_ff;
            s_wr_data = si_ff;
            x_in      = x_ff + 1'b1;
            kidx_in   = kidx_wrap ? '0 : (kidx_ff + 1'b1);
            if (x_ff == rc4cs_pkg::BYTE_ONES) begin
               sched_in = 1'b0;
               i_in     = '0;
               j_in     = '0;
               sum_in   = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_KS_RD;
            end
         end
         S_PR_J: begin
            si_in     = s_rd_data;
            j_in      = j_new;
            s_rd_addr = j_new;
            state_in  = S_PR_T;
         end
         S_PR_T: begin
            sj_in     = s_rd_data;
            s_wr_en   = 1'b1;
            s_wr_addr = i_ff;
            s_wr_data = s_rd_data;
            t_in      = t_new;
            s_rd_addr = t_new;
            state_in  = S_PR_WJ;
         end
         S_PR_WJ, S_OUT: begin
            if (state_ff == S_PR_WJ) begin
               s_wr_en   = 1'b1;
               s_wr_addr = j_ff;
               s_wr_data = si_ff;
               ks_in     = ks_fwd;
            end
            res_valid = 1'b1;
            if (res_ready) begin
               sum_in   = rc4cs_pkg::ones_add(sum_ff, sum_opnd);
               state_in = (encrypt && last_ff) ? S_CHK : S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_CHK: begin
            res_valid            = 1'b1;
            res.out_byte         = ~sum_ff;
            res.kind             = rc4cs_pkg::KIND_CHECK;
            res.checksum_ok      = 1'b0;
            res.end_of_run       = 1'b1;
            if (res_ready) begin
               sum_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_STAT: begin
            res_valid            = 1'b1;
            res.out_byte         = '0;
            res.kind             = rc4cs_pkg::KIND_STATUS;
            res.checksum_ok      = (stat_sum == rc4cs_pkg::BYTE_ONES);
            res.end_of_run       = 1'b1;
            if (res_ready) begin
               sum_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         x_ff     <= '0;
         kcnt_ff  <= '0;
         sched_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         kcnt_ff  <= kcnt_in;
         sched_ff <= sched_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         sum_ff   <= sum_in;
      end
      y_ff    <= y_in;
      kidx_ff <= kidx_in;
      len_ff  <= len_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      ks_ff   <= ks_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

// ===== sv/rc4cs_checker.sv =====
// ----------------------------------------------------------------------------
// rc4cs_checker
// Port-level checks on the result channel and the reset fill.
// ----------------------------------------------------------------------------
module rc4cs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic       rsp_checksum_ok,
   input logic       rsp_end_of_run
);

   // no result comes out of reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // sbox fill blocks input after reset
   a_reset_fill : assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during sbox fill");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_kind) && $stable(rsp_checksum_ok) && $stable(rsp_end_of_run))
      else $error("stalled result changed");

   // verify status closes the run and carries no byte
   a_status_form : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rc4cs_pkg::KIND_STATUS)
         |-> (rsp_out_byte == 8'h00) && rsp_end_of_run)
      else $error("malformed verify status");

   a_ok_only_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != rc4cs_pkg::KIND_STATUS) |-> !rsp_checksum_ok)
      else $error("checksum_ok set outside verify status");

endmodule

bind rc4_cipher_with_checksum rc4cs_checker u_rc4cs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_kind        (rsp_kind),
   .rsp_checksum_ok (rsp_checksum_ok),
   .rsp_end_of_run  (rsp_end_of_run)
);

// ===== tb/sv/rc4_cipher_with_checksum_test.sv =====
// ----------------------------------------------------------------------------
// rc4_cipher_with_checksum_test
// Self-checking bench for the RC4 cipher with one's-complement checksum.
// A local cipher tracker mirrors sbox, indices, key store and running sum,
// and queues the results each accepted item must produce. Items go in through
// bursty req_* traffic while rsp_* stalls on its own pattern. The run covers
// directed corner cases, then random keyed messages in both directions.
// ----------------------------------------------------------------------------
module rc4_cipher_with_checksum_test;

   localparam int KEY_LIMIT     = 256;
   localparam int KEY_OVERLONG  = 258;
   localparam int SETTLE_CYCLES = 1400;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 20000;

   class cipher_tracker;
      logic [7:0] sbox [256];
      logic [7:0] key_bytes [256];
      int         key_len;
      logic [7:0] idx_i;
      logic [7:0] idx_j;
      logic [7:0] run_sum;
      logic       dir;
      rc4cs_pkg::result_type pending_results [$];
      int         mismatch_count;
      int         results_seen;
      int         statuses_ok;
      int         schedules_run;
      int         messages_done;

      function new();
         for (int x = 0; x < 256; x++) begin
            sbox[x] = x[7:0];
            key_bytes[x] = 8'h00;
         end
         key_len = 0;
         idx_i = 8'h00;
         idx_j = 8'h00;
         run_sum = 8'h00;
         dir = rc4cs_pkg::DIR_ENCRYPT;
         mismatch_count = 0;
         results_seen = 0;
         statuses_ok = 0;
         schedules_run = 0;
         messages_done = 0;
      endfunction

      // end-around carry add
      function logic [7:0] fold_add(logic [7:0] a, logic [7:0] b);
         logic [8:0] t;
         t = {1'b0, a} + {1'b0, b};
         return t[8] ? t[7:0] + 8'd1 : t[7:0];
      endfunction

      function void rekey();
         int         len;
         logic [7:0] y;
         logic [7:0] t;
         len = (key_len == 0) ? 1 : key_len;
         for (int x = 0; x < 256; x++) sbox[x] = x[7:0];
         y = 8'h00;
         for (int x = 0; x < 256; x++) begin
            y = y + sbox[x] + key_bytes[x % len];
            t = sbox[x];
            sbox[x] = sbox[y];
            sbox[y] = t;
         end
         idx_i = 8'h00;
         idx_j = 8'h00;
         run_sum = 8'h00;
      endfunction

      function logic [7:0] next_keystream();
         logic [7:0] t;
         logic [7:0] p;
         idx_i = idx_i + 8'd1;
         idx_j = idx_j + sbox[idx_i];
         t = sbox[idx_i];
         sbox[idx_i] = sbox[idx_j];
         sbox[idx_j] = t;
         p = sbox[idx_i] + sbox[idx_j];
         return sbox[p];
      endfunction

      function void queue_result(logic [7:0] b, logic [rc4cs_pkg::KIND_W-1:0] k, logic ok,
                                 logic eor);
         rc4cs_pkg::result_type r;
         r.out_byte = b;
         r.kind = k;
         r.checksum_ok = ok;
         r.end_of_run = eor;
         pending_results = {pending_results, r};
      endfunction

      function void take_item(logic op, logic [7:0] b, logic last);
         logic [7:0] c;
         if (op == rc4cs_pkg::OP_KEY) begin
            // bytes past the key limit are dropped, but last still rekeys
            if (key_len < KEY_LIMIT) begin
               key_bytes[key_len] = b;
               key_len++;
            end
            if (last) begin
               rekey();
               key_len = 0;
               schedules_run++;
            end
            return;
         end
         if (last) messages_done++;
         if (dir == rc4cs_pkg::DIR_ENCRYPT) begin
            c = b ^ next_keystream();
            run_sum = fold_add(run_sum, c);
            queue_result(c, rc4cs_pkg::KIND_DATA, 1'b0, !last);
            if (last) begin
               queue_result(~run_sum, rc4cs_pkg::KIND_CHECK, 1'b0, 1'b1);
               run_sum = 8'h00;
            end
         end else begin
            run_sum = fold_add(run_sum, b);
            if (!last) begin
               queue_result(b ^ next_keystream(), rc4cs_pkg::KIND_DATA, 1'b0, 1'b1);
            end else begin
               // received checksum byte: summed, not deciphered, no keystream step
               queue_result(8'h00, rc4cs_pkg::KIND_STATUS, (~run_sum) == 8'h00, 1'b1);
               run_sum = 8'h00;
            end
         end
      endfunction

      task report(string msg);
         mismatch_count++;
         if (mismatch_count <= 30) $display("mismatch: %s", msg);
      endtask

      task check_result(rc4cs_pkg::result_type got);
         rc4cs_pkg::result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result with nothing expected: byte %h kind %0d",
                             got.out_byte, got.kind));
            return;
         end
         want = pending_results.pop_front();
         results_seen++;
         if (want.kind == rc4cs_pkg::KIND_STATUS && want.checksum_ok) statuses_ok++;
         if (got.out_byte !== want.out_byte)
            report($sformatf("result %0d out_byte %h, want %h",
                             results_seen, got.out_byte, want.out_byte));
         if (got.kind !== want.kind)
            report($sformatf("result %0d kind %0d, want %0d",
                             results_seen, got.kind, want.kind));
         if (got.checksum_ok !== want.checksum_ok)
            report($sformatf("result %0d checksum_ok %b, want %b",
                             results_seen, got.checksum_ok, want.checksum_ok));
         if (got.end_of_run !== want.end_of_run)
            report($sformatf("result %0d end_of_run %b, want %b",
                             results_seen, got.end_of_run, want.end_of_run));
      endtask

      task close_out();
         if (pending_results.size() != 0)
            report($sformatf("%0d expected results never arrived", pending_results.size()));
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_op = rc4cs_pkg::OP_KEY;
   logic [7:0]                          req_data_byte = 8'h00;
   logic                                req_last = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [7:0]                          rsp_out_byte;
   logic [rc4cs_pkg::KIND_W-1:0]        rsp_kind;
   logic                                rsp_checksum_ok;
   logic                                rsp_end_of_run;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [rc4cs_pkg::CSR_ADDR_W-1:0]    paddr = '0;
   logic [rc4cs_pkg::CSR_DATA_W-1:0]    pwdata = '0;
   logic [rc4cs_pkg::CSR_DATA_W-1:0]    prdata;
   logic                                pready;

   cipher_tracker tracker;
   int   items_sent = 0;
   int   burst_left = 0;
   bit   steady = 1'b0;
   int   hold_seq = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   stall_tick = 0;
   int   idle_cycles = 0;

   rc4_cipher_with_checksum uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_kind(rsp_kind),
      .rsp_checksum_ok(rsp_checksum_ok),
      .rsp_end_of_run(rsp_end_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // result side: check accepted items, then pick the next stall value
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result({rsp_out_byte, rsp_kind, rsp_checksum_ok, rsp_end_of_run});
         stall_tick++;
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= stall_tick[0];
            endcase
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[rc4_cipher_with_checksum] ERROR");
      $finish;
   end

   task automatic send_item(logic op, logic [7:0] b, logic last);
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      req_last <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.take_item(op, b, last);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (!steady) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_key(int n);
      for (int k = 0; k < n; k++) send_item(rc4cs_pkg::OP_KEY, 8'($urandom), k == n - 1);
   endtask

   // in decrypt the closing byte makes the folded total all ones unless corrupted
   task automatic send_message(int n, bit corrupt);
      logic [7:0] b;
      logic [7:0] sum;
      sum = 8'h00;
      for (int k = 0; k < n; k++) begin
         b = 8'($urandom);
         if (tracker.dir == rc4cs_pkg::DIR_DECRYPT && k == n - 1) begin
            if (!corrupt) b = ~sum;
         end else begin
            sum = tracker.fold_add(sum, b);
         end
         send_item(rc4cs_pkg::OP_DATA, b, k == n - 1);
      end
   endtask

   task automatic send_noise();
      int   n;
      logic op;
      n = $urandom_range(1, 3);
      repeat (n) begin
         op = 1'($urandom);
         send_item(op, 8'($urandom),
                   (op == rc4cs_pkg::OP_KEY) ? ($urandom_range(0, 3) == 0) : 1'($urandom));
      end
   endtask

   task automatic random_phase(int n_items, bit long_key);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (long_key && items_sent - start > n_items / 2) begin
            send_key(KEY_OVERLONG);
            long_key = 1'b0;
         end else if (pick < 15) begin
            send_key(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 16));
         end else if (pick < 85) begin
            send_message(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12),
                         $urandom_range(0, 6) == 0);
         end else begin
            send_noise();
         end
      end
   endtask

   // drain results, then cover a key schedule that may still be running
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [rc4cs_pkg::CSR_IDX_W-1:0] idx,
                             logic [rc4cs_pkg::CSR_DATA_W-1:0] value,
                             output logic [rc4cs_pkg::CSR_DATA_W-1:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_direction(logic d);
      logic [rc4cs_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b1, rc4cs_pkg::REG_DIRECTION, {{(rc4cs_pkg::CSR_DATA_W-1){1'b0}}, d}, rd);
      tracker.dir = d;
      @(posedge clock);
      csr_access(1'b0, rc4cs_pkg::REG_DIRECTION, '0, rd);
      if (rd !== {{(rc4cs_pkg::CSR_DATA_W-1){1'b0}}, d})
         tracker.report($sformatf("direction reads back %h, want %b", rd, d));
   endtask

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_direction(rc4cs_pkg::DIR_ENCRYPT);

      // keystream from the identity sbox before any key
      send_item(rc4cs_pkg::OP_DATA, 8'h00, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b1);
      send_item(rc4cs_pkg::OP_KEY, 8'hFF, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'hA5, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'h5A, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'h00, 1'b1);
      send_item(rc4cs_pkg::OP_KEY, 8'h00, 1'b0);
      send_item(rc4cs_pkg::OP_KEY, 8'h01, 1'b0);
      send_item(rc4cs_pkg::OP_KEY, 8'h80, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b1);
      // plain key byte inside a message leaves it alone
      send_item(rc4cs_pkg::OP_DATA, 8'h11, 1'b0);
      send_item(rc4cs_pkg::OP_KEY, 8'h22, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'h33, 1'b1);
      // closing key byte inside a message rekeys and clears the sum
      send_item(rc4cs_pkg::OP_DATA, 8'h44, 1'b0);
      send_item(rc4cs_pkg::OP_KEY, 8'h55, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'h66, 1'b1);
      settle();

      set_direction(rc4cs_pkg::DIR_DECRYPT);
      send_item(rc4cs_pkg::OP_DATA, 8'h12, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'h34, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'hB9, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'h00, 1'b1);
      // end-around carry on the sum
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'hFF, 1'b1);
      send_item(rc4cs_pkg::OP_DATA, 8'h80, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'h80, 1'b0);
      send_item(rc4cs_pkg::OP_DATA, 8'hFE, 1'b1);
      settle();

      set_direction(rc4cs_pkg::DIR_ENCRYPT);
      // long result hold while a message keeps coming, fills the block
      hold_seq <= hold_seq + 1;
      steady = 1'b1;
      send_message(40, 1'b0);
      steady = 1'b0;
      random_phase(400, 1'b0);
      settle();
      set_direction(rc4cs_pkg::DIR_DECRYPT);
      random_phase(400, 1'b0);
      settle();
      set_direction(rc4cs_pkg::DIR_ENCRYPT);
      random_phase(460, 1'b1);
      settle();
      set_direction(rc4cs_pkg::DIR_DECRYPT);
      random_phase(380, 1'b0);
      settle();

      tracker.close_out();
      $display("covered %0d items in both directions: %0d key schedules, %0d messages",
               items_sent, tracker.schedules_run, tracker.messages_done);
      $display("checked %0d results, %0d of them good checksum verifications",
               tracker.results_seen, tracker.statuses_ok);
      if (tracker.mismatch_count == 0) begin
         $display("[rc4_cipher_with_checksum] OK");
      end else begin
         $display("[rc4_cipher_with_checksum] ERROR");
      end
      $finish;
   end

endmodule
